/* rtl/somr_pkg.sv */
// shared constants, types and helpers for the spiral order matrix reader
package somr_pkg;

  localparam int SIDE_DEF = 5;
  localparam int VALUE_W  = 32;
  localparam int COORD_W  = 3;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_RIGHT,
    WALK_DOWN,
    WALK_LEFT,
    WALK_UP
  } somr_walk_t;

  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } somr_req_t;

  function automatic int somr_addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* rtl/somr_store.sv */
// element store: one write port, one registered read port
module somr_store import somr_pkg::*; #(
  parameter int DEPTH = SIDE_DEF * SIDE_DEF,
  parameter int AW    = somr_addr_w(SIDE_DEF * SIDE_DEF)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem_r [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/somr_walker.sv */
// spiral walk sequencer: moves four bounds and steps the read address with one adder
module somr_walker import somr_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  parameter int AW   = somr_addr_w(SIDE_DEF * SIDE_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  output logic          busy,
  output somr_req_t     req,
  output logic [AW-1:0] rd_addr
);

  localparam int                 N       = SIDE * SIDE;
  localparam logic [COORD_W-1:0] MAX_IDX = COORD_W'(SIDE - 1);
  localparam logic [COORD_W-1:0] ONE_C   = COORD_W'(1);
  localparam logic [AW-1:0]      LAST_K  = AW'(N - 1);
  localparam logic [AW-1:0]      STEP_P1 = AW'(1);
  localparam logic [AW-1:0]      STEP_M1 = AW'((2 ** AW) - 1);
  localparam logic [AW-1:0]      STEP_PS = AW'(SIDE);
  localparam logic [AW-1:0]      STEP_MS = AW'((2 ** AW) - SIDE);

  somr_walk_t         state_r, state_nxt;
  logic [COORD_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [COORD_W-1:0] top_r, top_nxt, bottom_r, bottom_nxt;
  logic [COORD_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [AW-1:0]      addr_r, addr_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0]      step;
  logic               walking, at_end;

  assign walking = (state_r != WALK_IDLE);
  assign at_end  = (cnt_r == LAST_K);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WALK_IDLE: begin
        if (go) state_nxt = WALK_RIGHT;
      end
      WALK_RIGHT: begin
        if (at_end) state_nxt = WALK_IDLE;
        else if (col_r == right_r) state_nxt = WALK_DOWN;
      end
      WALK_DOWN: begin
        if (at_end) state_nxt = WALK_IDLE;
        else if (row_r == bottom_r) state_nxt = WALK_LEFT;
      end
      WALK_LEFT: begin
        if (at_end) state_nxt = WALK_IDLE;
        else if (col_r == left_r) state_nxt = WALK_UP;
      end
      WALK_UP: begin
        if (at_end) state_nxt = WALK_IDLE;
        else if (row_r == top_r) state_nxt = WALK_RIGHT;
      end
      default: state_nxt = WALK_IDLE;
    endcase
  end

  // position, bounds and address
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    cnt_nxt    = cnt_r;
    step       = STEP_P1;
    case (state_nxt)
      WALK_RIGHT: step = STEP_P1;
      WALK_DOWN:  step = STEP_PS;
      WALK_LEFT:  step = STEP_M1;
      WALK_UP:    step = STEP_MS;
      default:    step = STEP_P1;
    endcase
    addr_nxt = addr_r + step;

    if (!walking) begin
      row_nxt    = '0;
      col_nxt    = '0;
      top_nxt    = '0;
      bottom_nxt = MAX_IDX;
      left_nxt   = '0;
      right_nxt  = MAX_IDX;
      addr_nxt   = '0;
      cnt_nxt    = '0;
    end else if (!at_end) begin
      cnt_nxt = cnt_r + AW'(1);
      // a turn pulls in the bound of the side just finished
      if (state_r == WALK_RIGHT && state_nxt == WALK_DOWN)  top_nxt    = top_r + ONE_C;
      if (state_r == WALK_DOWN  && state_nxt == WALK_LEFT)  right_nxt  = right_r - ONE_C;
      if (state_r == WALK_LEFT  && state_nxt == WALK_UP)    bottom_nxt = bottom_r - ONE_C;
      if (state_r == WALK_UP    && state_nxt == WALK_RIGHT) left_nxt   = left_r + ONE_C;
      case (state_nxt)
        WALK_RIGHT: col_nxt = col_r + ONE_C;
        WALK_DOWN:  row_nxt = row_r + ONE_C;
        WALK_LEFT:  col_nxt = col_r - ONE_C;
        WALK_UP:    row_nxt = row_r - ONE_C;
        default:    row_nxt = row_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WALK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    top_r    <= top_nxt;
    bottom_r <= bottom_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    addr_r   <= addr_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign busy     = walking;
  assign rd_addr  = addr_r;
  assign req.vld  = walking;
  assign req.row  = row_r;
  assign req.col  = col_r;
  assign req.last = walking && at_end;

  a_addr_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (addr_r == AW'(int'(row_r) * SIDE + int'(col_r))))
    else $error("read address out of step with row and column");

  a_pos_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (row_r >= top_r && row_r <= bottom_r && col_r >= left_r && col_r <= right_r))
    else $error("walk position outside current ring");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (walking && at_end) |=> !walking)
    else $error("walk continued after last element");

  a_go_starts_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !walking) |=> (walking && addr_r == '0 && cnt_r == '0))
    else $error("walk did not start at top-left corner");

endmodule

/* rtl/spiral_order_matrix_reader_core.sv */
// top level of the spiral order matrix reader
//
//   channel  | ports                                          | flow control
//   ---------+------------------------------------------------+------------------------
//   input    | start, busy, in_value                          | transfer on start & !busy
//   result   | out_valid, out_value_res, out_row, out_col,    | one-cycle strobe,
//            | out_last                                       | receiver cannot stall
//
// - each element is a one-cycle transfer while busy is low; it is written into the store
// - the transfer of the final element (SIDE*SIDE of them) raises busy for the whole walk
//   while the walk sequencer steps one store address per cycle
// - results follow in the cycle after each address (registered store read), so the first
//   result comes after the walk state and store read registers, and one result comes per cycle
// - reset clears the load count, the walk state and the result strobe; store contents stay
// - no backpressure on results; the next matrix may load during the last result cycle
module spiral_order_matrix_reader_core import somr_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  output logic signed [VALUE_W-1:0]  out_value_res,
  output logic        [COORD_W-1:0]  out_row,
  output logic        [COORD_W-1:0]  out_col,
  output logic                       out_last
);

  localparam int            N      = SIDE * SIDE;
  localparam int            AW     = somr_addr_w(N);
  localparam logic [AW-1:0] LAST_K = AW'(N - 1);

  // load side
  logic          accept;
  logic          go;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;

  // walk side
  logic               walk_busy;
  somr_req_t          req;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // result stage
  logic               out_valid_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;
  logic               out_last_r;

  // an element transfer happens only while no walk runs
  assign accept = start && !walk_busy;
  // the final element of the matrix kicks off the spiral walk
  assign go     = accept && (load_cnt_r == LAST_K);

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (go) begin
      load_cnt_nxt = '0;
    end else if (accept) begin
      load_cnt_nxt = load_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

  somr_store #(
    .DEPTH (N),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (load_cnt_r),
    .wr_data ($unsigned(in_value)),
    .rd_en   (req.vld),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  somr_walker #(
    .SIDE (SIDE),
    .AW   (AW)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .busy    (walk_busy),
    .req     (req),
    .rd_addr (rd_addr)
  );

  // result stage lines up row, column and last flag with the registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= req.row;
    out_col_r  <= req.col;
    out_last_r <= req.last;
  end

  assign busy          = walk_busy;
  assign out_valid     = out_valid_r;
  assign out_value_res = $signed(rd_data);
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_last      = out_valid_r && out_last_r;

  a_no_load_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |-> !accept)
    else $error("element transfer accepted during walk");

  a_go_raises_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> (walk_busy && load_cnt_r == '0))
    else $error("final element did not start walk");

  a_result_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    req.vld |=> out_valid)
    else $error("result strobe lost");

endmodule

/* bench/testbench.sv */
// self-checking bench for the spiral order matrix reader: row-major load, spiral drain
`timescale 1ns / 1ps

module testbench;
  import somr_pkg::*;

  localparam int SIDE        = SIDE_DEF;
  localparam int CELLS       = SIDE * SIDE;
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic                      last;
  } spiral_item_t;

  logic                      clk      = 1'b0;
  logic                      rst_n    = 1'b0;
  logic                      start    = 1'b0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      busy;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value_res;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;
  logic                      out_last;

  // shadow of the element store and load position
  logic signed [VALUE_W-1:0] matrix_shadow [CELLS];
  int                        fill_count = 0;
  spiral_item_t              pending_spiral [$];

  int errors           = 0;
  int elements_sent    = 0;
  int matrices_drained = 0;
  int results_checked  = 0;
  int quiet_cycles     = 0;

  spiral_order_matrix_reader_core #(.SIDE(SIDE)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_value_res(out_value_res),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // queue one spiral element read from the shadow store
  function automatic void push_cell(input int r, input int c);
    spiral_item_t item;
    item.value = matrix_shadow[r * SIDE + c];
    item.row   = COORD_W'(r);
    item.col   = COORD_W'(c);
    item.last  = (pending_spiral.size() % CELLS) == CELLS - 1;
    pending_spiral.push_back(item);
  endfunction

  // clockwise walk over four shrinking bounds; the bottom-row and left-column
  // passes are guarded so the innermost ring is not visited twice
  function automatic void unroll_spiral();
    int top, bottom, lft, rgt, i;
    top    = 0;
    bottom = SIDE - 1;
    lft    = 0;
    rgt    = SIDE - 1;
    while (top <= bottom && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) push_cell(top, i);
      top++;
      for (i = top; i <= bottom; i++) push_cell(i, rgt);
      rgt--;
      if (top <= bottom) begin
        for (i = rgt; i >= lft; i--) push_cell(bottom, i);
        bottom--;
      end
      if (lft <= rgt) begin
        for (i = bottom; i >= top; i--) push_cell(i, lft);
        lft++;
      end
    end
  endfunction

  // store one element; the final one of a matrix releases the whole spiral
  function automatic void take_element(input logic signed [VALUE_W-1:0] v);
    matrix_shadow[fill_count] = v;
    if (fill_count == CELLS - 1) begin
      fill_count = 0;
      matrices_drained++;
      unroll_spiral();
    end else begin
      fill_count++;
    end
  endfunction

  // result checker and input predictor, both sampled at the rising edge
  always @(posedge clk) begin
    spiral_item_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid) begin
        results_checked++;
        if (pending_spiral.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d row=%0d col=%0d last=%0b",
                   $time, out_value_res, out_row, out_col, out_last);
        end else begin
          want = pending_spiral.pop_front();
          if (out_value_res !== want.value || out_row !== want.row ||
              out_col !== want.col || out_last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected value=%0d row=%0d col=%0d last=%0b",
                     $time, want.value, want.row, want.col, want.last);
            $display("%0t:          actual   value=%0d row=%0d col=%0d last=%0b",
                     $time, out_value_res, out_row, out_col, out_last);
          end
        end
      end
      if (start && !busy) begin
        elements_sent++;
        take_element(in_value);
      end
      quiet_cycles <= ((start && !busy) || out_valid) ? 0 : quiet_cycles + 1;
    end
  end

  // ends the run if nothing moves on either channel for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // one element transfer; start stays high while the block is busy
  task automatic send_element(input logic signed [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with junk on the data port
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) begin
        in_value <= $urandom;
        @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one full matrix of corner values, bit patterns and sign edges
  task automatic test_extreme_values();
    logic signed [VALUE_W-1:0] v;
    int k;
    for (k = 0; k < CELLS; k++) begin
      case (k % 8)
        0: v = {1'b1, {(VALUE_W-1){1'b0}}};
        1: v = {1'b0, {(VALUE_W-1){1'b1}}};
        2: v = '0;
        3: v = '1;
        4: v = 32'h5555_5555;
        5: v = 32'hAAAA_AAAA;
        6: v = 32'sd1 << (k % VALUE_W);
        default: v = k;
      endcase
      send_element(v);
    end
    hold_off(3);
  endtask

  // matrices with no sender gaps: the next load starts as soon as busy drops
  task automatic test_back_to_back_matrices();
    int k;
    for (k = 0; k < 2 * CELLS; k++) send_element($urandom);
    hold_off(1);
  endtask

  // bursts of random length and random gaps, with stretches of no gaps at all
  task automatic test_random_traffic(input int matrices);
    int left_to_send, burst, gap;
    left_to_send = matrices * CELLS;
    while (left_to_send > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left_to_send) burst = left_to_send;
      repeat (burst) send_element(pick_value());
      left_to_send -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (left_to_send > 0) hold_off(gap);
    end
    hold_off(1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_values();
    test_back_to_back_matrices();
    test_random_traffic(16);

    while (pending_spiral.size() != 0) @(negedge clk);
    repeat (CELLS + 4) @(posedge clk);
    if (pending_spiral.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_spiral.size());
    end

    $display("run covered %0d element transfers over %0d full matrices of side %0d",
             elements_sent, matrices_drained, SIDE);
    $display("%0d spiral results compared, %0d errors", results_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/somr_pkg.sv
rtl/somr_store.sv
rtl/somr_walker.sv
rtl/spiral_order_matrix_reader_core.sv
bench/testbench.sv
